/* hw/rtl/cbs_pkg.sv */
`timescale 1ns / 1ps
// cbs_pkg: widths, payload types and beat structures of the cubic Bezier sampler
// no dependencies; used by the interfaces and by every module of the block
package cbs_pkg;

   // fixed field widths
   localparam int COORD_W = 16;
   localparam int COEF_W  = 20;
   localparam int TPOW_W  = 16;
   localparam int TFRAC   = 16;
   localparam int POS_W   = 24;
   localparam int IDX_W   = 6;

   // coefficient times a power of t, both kept signed
   localparam int PROD_W  = COEF_W + TPOW_W + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic        [TPOW_W-1:0]  tpow_type;
   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic        [IDX_W-1:0]   idx_type;

   localparam pos_type POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam pos_type POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   // power-basis coefficients of one axis plus its start point
   typedef struct packed {
      coef_type  a;
      coef_type  b;
      coef_type  c;
      coord_type p0;
   } axis_coef_type;

   // index 0 is x, index 1 is y
   typedef axis_coef_type [1:0] curve_coef_type;

   typedef struct packed {
      idx_type index;
      logic    last;
   } sample_meta_type;

   // one sample job handed from the sequencer to the evaluator
   typedef struct packed {
      curve_coef_type  coef;
      tpow_type        t1;
      tpow_type        t2;
      tpow_type        t3;
      sample_meta_type meta;
   } issue_beat_type;

endpackage

/* hw/rtl/cbs_if.sv */
`timescale 1ns / 1ps
// cbs_req_if and cbs_rsp_if: valid/ready channels of the cubic Bezier sampler
// depends on cbs_pkg for the field types
interface cbs_req_if;
   logic              valid;
   logic              ready;
   cbs_pkg::coord_type p0_x;
   cbs_pkg::coord_type p0_y;
   cbs_pkg::coord_type p1_x;
   cbs_pkg::coord_type p1_y;
   cbs_pkg::coord_type p2_x;
   cbs_pkg::coord_type p2_y;
   cbs_pkg::coord_type p3_x;
   cbs_pkg::coord_type p3_y;

   modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                   input ready);
   modport sink   (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                   output ready);
endinterface

interface cbs_rsp_if;
   logic             valid;
   logic             ready;
   cbs_pkg::pos_type x_pos;
   cbs_pkg::pos_type y_pos;
   cbs_pkg::idx_type sample_index;
   logic             last;

   modport source (output valid, x_pos, y_pos, sample_index, last, input ready);
   modport sink   (input valid, x_pos, y_pos, sample_index, last, output ready);
endinterface

/* hw/rtl/cbs_issue.sv */
`timescale 1ns / 1ps
// cbs_issue: coefficient setup, sample sequencer and powers-of-t table
// depends on cbs_pkg and cbs_req_if; feeds cbs_eval with one beat per sample
module cbs_issue #(
   parameter int SAMPLES = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   cbs_req_if.sink                 req_ch,
   output logic                    beat_valid,
   output cbs_pkg::issue_beat_type beat,
   input  logic                    beat_ready
);
   import cbs_pkg::*;

   localparam int CNT_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int TAB_DEPTH = 1 << CNT_W;

   // powers of t, one entry per sample, padding entries unused
   tpow_type t1_tab [TAB_DEPTH];
   tpow_type t2_tab [TAB_DEPTH];
   tpow_type t3_tab [TAB_DEPTH];

   for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tpow
      if (g < SAMPLES) begin : g_live
         localparam longint unsigned NUM  = g + 1;
         localparam longint unsigned DEN  = SAMPLES + 1;
         localparam longint unsigned ONE  = 64'd1 << TFRAC;
         localparam longint unsigned V1   = (NUM * ONE + DEN / 2) / DEN;
         localparam longint unsigned V2   =
            (NUM * NUM * ONE + (DEN * DEN) / 2) / (DEN * DEN);
         localparam longint unsigned V3   =
            (NUM * NUM * NUM * ONE + (DEN * DEN * DEN) / 2) / (DEN * DEN * DEN);
         assign t1_tab[g] = TPOW_W'(V1);
         assign t2_tab[g] = TPOW_W'(V2);
         assign t3_tab[g] = TPOW_W'(V3);
      end else begin : g_pad
         assign t1_tab[g] = '0;
         assign t2_tab[g] = '0;
         assign t3_tab[g] = '0;
      end
   end

   // c = 3(p1-p0), b = 3(p2-p1) - c, a = (p3-p0) - 3(p2-p1)
   function automatic axis_coef_type make_axis(input coord_type p0, input coord_type p1,
                                               input coord_type p2, input coord_type p3);
      coef_type      d10;
      coef_type      d21;
      coef_type      d30;
      coef_type      c3;
      coef_type      t3;
      axis_coef_type r;
      d10  = COEF_W'(p1) - COEF_W'(p0);
      d21  = COEF_W'(p2) - COEF_W'(p1);
      d30  = COEF_W'(p3) - COEF_W'(p0);
      c3   = d10 + (d10 <<< 1);
      t3   = d21 + (d21 <<< 1);
      r.c  = c3;
      r.b  = t3 - c3;
      r.a  = d30 - t3;
      r.p0 = p0;
      return r;
   endfunction

   logic            busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   curve_coef_type  coef_ff, coef_in;
   logic            s1_v_ff, s1_v_in;
   issue_beat_type  s1_ff, s1_in;
   logic            s1_adv;
   logic            cnt_last;
   logic            req_take;
   curve_coef_type  new_coef;

   // handshake and coefficients of the incoming curve
   always_comb begin
      s1_adv       = !s1_v_ff || beat_ready;
      cnt_last     = (cnt_ff == CNT_W'(SAMPLES - 1));
      req_ch.ready = !busy_ff || (s1_adv && cnt_last);
      req_take     = req_ch.valid && req_ch.ready;
      new_coef[0]  = make_axis(req_ch.p0_x, req_ch.p1_x, req_ch.p2_x, req_ch.p3_x);
      new_coef[1]  = make_axis(req_ch.p0_y, req_ch.p1_y, req_ch.p2_y, req_ch.p3_y);
   end

   // sequencer: one sample per cycle while a curve is loaded and beat_ready allows
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      coef_in = coef_ff;
      s1_v_in = s1_v_ff;
      s1_in   = s1_ff;
      if (s1_adv) begin
         s1_v_in = busy_ff;
         if (busy_ff) begin
            s1_in.coef       = coef_ff;
            s1_in.t1         = t1_tab[cnt_ff];
            s1_in.t2         = t2_tab[cnt_ff];
            s1_in.t3         = t3_tab[cnt_ff];
            s1_in.meta.index = IDX_W'(cnt_ff);
            s1_in.meta.last  = cnt_last;
            if (cnt_last) begin
               busy_in = 1'b0;
               cnt_in  = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
      end
      // a new curve may load in the cycle its predecessor issues its final sample
      if (req_take) begin
         coef_in = new_coef;
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         coef_ff <= '0;
         s1_v_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         coef_ff <= coef_in;
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign beat_valid = s1_v_ff;
   assign beat       = s1_ff;

   // a loaded curve always starts at its first sample
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> busy_ff && (cnt_ff == '0))
      else $error("curve load did not restart the sequencer");

   // the final-sample flag sits on the last index only
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s1_ff.meta.last) |-> (s1_ff.meta.index == IDX_W'(SAMPLES - 1)))
      else $error("last flag on a wrong sample index");

   // the sequencer only goes idle right after issuing the final sample
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy_ff)) |-> $past(cnt_last && s1_adv))
      else $error("sequencer stopped before the final sample");

endmodule

/* hw/rtl/cbs_eval.sv */
`timescale 1ns / 1ps
// cbs_eval: multiply, accumulate, round and saturate pipeline for both axes
// depends on cbs_pkg and cbs_rsp_if; takes sample beats from cbs_issue
module cbs_eval #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    beat_valid,
   input  cbs_pkg::issue_beat_type beat,
   output logic                    beat_ready,
   cbs_rsp_if.source               rsp_ch
);
   import cbs_pkg::*;

   localparam int ACC_W = PROD_W + 3;
   localparam int SH    = TFRAC - FRACTION_BITS;
   localparam logic signed [ACC_W-1:0] HALF = (ACC_W'(1) << SH) >>> 1;

   logic adv2, adv3, adv4;
   logic v2_ff, v3_ff, v4_ff;
   sample_meta_type meta2_ff, meta3_ff, meta4_ff;

   logic signed [PROD_W-1:0] pa_in [2];
   logic signed [PROD_W-1:0] pb_in [2];
   logic signed [PROD_W-1:0] pc_in [2];
   logic signed [PROD_W-1:0] pa_ff [2];
   logic signed [PROD_W-1:0] pb_ff [2];
   logic signed [PROD_W-1:0] pc_ff [2];
   coord_type                p0_ff [2];
   logic signed [ACC_W-1:0]  ab_in [2];
   logic signed [ACC_W-1:0]  cp_in [2];
   logic signed [ACC_W-1:0]  ab_ff [2];
   logic signed [ACC_W-1:0]  cp_ff [2];
   pos_type                  pos_in [2];
   pos_type                  pos_ff [2];

   // stall chain from the output register back to the sequencer
   always_comb begin
      adv4       = !v4_ff || rsp_ch.ready;
      adv3       = !v3_ff || adv4;
      adv2       = !v2_ff || adv3;
      beat_ready = adv2;
   end

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis
      logic signed [ACC_W-1:0]   sum_w;
      logic signed [ACC_W-1:0]   shr_w;
      logic [ACC_W-POS_W:0]      upper_w;

      // products with the powers of t
      assign pa_in[ax] = PROD_W'(beat.coef[ax].a) * PROD_W'($signed({1'b0, beat.t3}));
      assign pb_in[ax] = PROD_W'(beat.coef[ax].b) * PROD_W'($signed({1'b0, beat.t2}));
      assign pc_in[ax] = PROD_W'(beat.coef[ax].c) * PROD_W'($signed({1'b0, beat.t1}));

      // two partial sums, rounding offset folded in
      assign ab_in[ax] = ACC_W'(pa_ff[ax]) + ACC_W'(pb_ff[ax]);
      assign cp_in[ax] = ACC_W'(pc_ff[ax])
                       + ACC_W'($signed({p0_ff[ax], {TFRAC{1'b0}}})) + HALF;

      // final sum, drop fraction bits, clamp to the output range
      assign sum_w   = ab_ff[ax] + cp_ff[ax];
      assign shr_w   = sum_w >>> SH;
      assign upper_w = shr_w[ACC_W-1:POS_W-1];
      assign pos_in[ax] = ((&upper_w) || !(|upper_w)) ? shr_w[POS_W-1:0]
                        : (shr_w[ACC_W-1] ? POS_MIN : POS_MAX);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv2) v2_ff <= beat_valid;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv2) meta2_ff <= beat.meta;
      if (adv3) meta3_ff <= meta2_ff;
      if (adv4) meta4_ff <= meta3_ff;
      for (int i = 0; i < 2; i++) begin
         if (adv2) begin
            pa_ff[i] <= pa_in[i];
            pb_ff[i] <= pb_in[i];
            pc_ff[i] <= pc_in[i];
            p0_ff[i] <= beat.coef[i].p0;
         end
         if (adv3) begin
            ab_ff[i] <= ab_in[i];
            cp_ff[i] <= cp_in[i];
         end
         if (adv4) begin
            pos_ff[i] <= pos_in[i];
         end
      end
   end

   assign rsp_ch.valid        = v4_ff;
   assign rsp_ch.x_pos        = pos_ff[0];
   assign rsp_ch.y_pos        = pos_ff[1];
   assign rsp_ch.sample_index = meta4_ff.index;
   assign rsp_ch.last         = meta4_ff.last;

   // a sample moving into the output stage is never dropped
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && adv4) |=> v4_ff)
      else $error("sample lost between sum and output stage");

   // a stalled product stage keeps its sample
   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !adv3) |=> (v2_ff && $stable(meta2_ff)))
      else $error("product stage changed while stalled");

endmodule

/* hw/rtl/cubic_bezier_sampler.sv */
`timescale 1ns / 1ps
// cubic_bezier_sampler: top level, samples a cubic Bezier curve at interior points
// depends on cbs_pkg, cbs_if, cbs_issue and cbs_eval
//
//   channel   dir   handshake          beat
//   req_ch    in    valid / ready      control points p0..p3, x and y
//   rsp_ch    out   valid / ready      x_pos, y_pos, sample_index, last
//
// one curve yields SAMPLES beats, one per cycle unless rsp_ch.ready stalls them;
// the sample sequencer in cbs_issue issues them, and a new curve loads as the last
// sample of the previous one issues
// each sample passes the issue, product, partial-sum and output registers in turn
// reset is synchronous and clears the sequencer and all valid bits
// low rsp_ch.ready holds every occupied stage while empty stages still fill;
// req_ch.ready is low while a curve is issuing, but for its last sample
module cubic_bezier_sampler #(
   parameter int SAMPLES       = 18,
   parameter int FRACTION_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   cbs_req_if.sink    req_ch,
   cbs_rsp_if.source  rsp_ch
);
   import cbs_pkg::*;

   logic           beat_valid;
   logic           beat_ready;
   issue_beat_type beat;

   // coefficient setup and sample sequencing
   cbs_issue #(
      .SAMPLES (SAMPLES)
   ) u_issue (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_ready (beat_ready)
   );

   // polynomial evaluation pipeline
   cbs_eval #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_eval (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_ready (beat_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for cubic_bezier_sampler, control points in and samples out
// depends on cbs_pkg, cbs_req_if / cbs_rsp_if and the cubic_bezier_sampler rtl
module tb_top;
   import cbs_pkg::*;

   localparam int SAMPLES       = 18;
   localparam int FRACTION_BITS = 8;
   localparam int TBITS         = 16;
   localparam int IDLE_PCT      = 8;

   localparam coord_type C_MAX = 16'sh7fff;
   localparam coord_type C_MIN = -16'sh8000;

   typedef struct {
      coord_type p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
   } curve_type;

   typedef struct {
      pos_type x_pos;
      pos_type y_pos;
      idx_type sample_index;
      logic    last;
   } sample_type;

   logic clock = 1'b0;
   logic reset;
   bit   idle_enable = 1'b1;
   int   mismatch_count = 0;
   int   curve_count = 0;
   int   samples_checked = 0;

   sample_type expected_samples[$];

   cbs_req_if req_ch ();
   cbs_rsp_if rsp_ch ();

   cubic_bezier_sampler #(
      .SAMPLES       (SAMPLES),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // t^n for t = (k+1)/(SAMPLES+1), 16 fractional bits, nearest with ties up
   function automatic longint t_power(int k, int n);
      longint unsigned num;
      longint unsigned den;
      num = 1;
      den = 1;
      for (int i = 0; i < n; i++) begin
         num = num * longint'(k + 1);
         den = den * longint'(SAMPLES + 1);
      end
      num = num << TBITS;
      return longint'((num + den / 2) / den);
   endfunction

   // one axis of one sample: power basis, exact sum, round and saturate
   function automatic pos_type axis_position(int p0, int p1, int p2, int p3, int k);
      int     ca;
      int     cb;
      int     cc;
      longint acc;
      longint rounded;
      int     sh;
      cc = 3 * (p1 - p0);
      cb = 3 * (p2 - p1) - cc;
      ca = p3 - p0 - cc - cb;
      sh = TBITS - FRACTION_BITS;
      acc = longint'(ca) * t_power(k, 3) + longint'(cb) * t_power(k, 2)
          + longint'(cc) * t_power(k, 1) + (longint'(p0) <<< TBITS);
      if (sh > 0)
         acc = acc + (longint'(1) <<< (sh - 1));
      rounded = acc >>> sh;
      if (rounded > longint'(POS_MAX))
         rounded = longint'(POS_MAX);
      if (rounded < longint'(POS_MIN))
         rounded = longint'(POS_MIN);
      return pos_type'(rounded);
   endfunction

   // queue up every sample an accepted curve must produce
   function automatic void predict_samples(curve_type cv);
      sample_type s;
      for (int k = 0; k < SAMPLES; k++) begin
         s.x_pos        = axis_position(cv.p0_x, cv.p1_x, cv.p2_x, cv.p3_x, k);
         s.y_pos        = axis_position(cv.p0_y, cv.p1_y, cv.p2_y, cv.p3_y, k);
         s.sample_index = idx_type'(k);
         s.last         = (k == SAMPLES - 1);
         expected_samples.push_back(s);
      end
   endfunction

   function automatic curve_type make_curve(coord_type p0x, coord_type p0y,
                                            coord_type p1x, coord_type p1y,
                                            coord_type p2x, coord_type p2y,
                                            coord_type p3x, coord_type p3y);
      curve_type cv;
      cv.p0_x = p0x; cv.p0_y = p0y;
      cv.p1_x = p1x; cv.p1_y = p1y;
      cv.p2_x = p2x; cv.p2_y = p2y;
      cv.p3_x = p3x; cv.p3_y = p3y;
      return cv;
   endfunction

   // mix of full-range, extreme and small coordinates
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0, 1: begin
            case ($urandom_range(0, 4))
               0: return C_MAX;
               1: return C_MIN;
               2: return 16'sd0;
               3: return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         2, 3: return coord_type'(int'($urandom_range(0, 64)) - 32);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic curve_type rand_curve();
      return make_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endfunction

   // drive one curve beat and hold it until accepted
   task automatic send_curve(curve_type cv);
      int gap;
      gap = 0;
      if (idle_enable)
         while ($urandom_range(0, 99) < IDLE_PCT)
            gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.p0_x  <= cv.p0_x;
      req_ch.p0_y  <= cv.p0_y;
      req_ch.p1_x  <= cv.p1_x;
      req_ch.p1_y  <= cv.p1_y;
      req_ch.p2_x  <= cv.p2_x;
      req_ch.p2_y  <= cv.p2_y;
      req_ch.p3_x  <= cv.p3_x;
      req_ch.p3_y  <= cv.p3_y;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      predict_samples(cv);
      curve_count++;
   endtask

   // stop sending and let every outstanding sample come back
   task automatic wait_all_samples();
      req_ch.valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
   endtask

   // sink side: random back-pressure and in-order compare
   always @(posedge clock) begin
      sample_type want;
      rsp_ch.ready <= !(idle_enable && ($urandom_range(0, 99) < IDLE_PCT));
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         samples_checked++;
         if (expected_samples.size() == 0) begin
            $error("unexpected sample beat: index %0d x_pos %0d y_pos %0d",
                   rsp_ch.sample_index, rsp_ch.x_pos, rsp_ch.y_pos);
            mismatch_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_ch.x_pos !== want.x_pos) begin
               $error("x_pos: expected %0d, got %0d", want.x_pos, rsp_ch.x_pos);
               mismatch_count++;
            end
            if (rsp_ch.y_pos !== want.y_pos) begin
               $error("y_pos: expected %0d, got %0d", want.y_pos, rsp_ch.y_pos);
               mismatch_count++;
            end
            if (rsp_ch.sample_index !== want.sample_index) begin
               $error("sample_index: expected %0d, got %0d",
                      want.sample_index, rsp_ch.sample_index);
               mismatch_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
               mismatch_count++;
            end
         end
      end
   end

   // corner control points: range limits, maximal bulge, bit patterns
   task automatic test_extreme_points();
      send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0));
      send_curve(make_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
      send_curve(make_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
      send_curve(make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN));
      send_curve(make_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX));
      // outer points on one bound, inner points on the other
      send_curve(make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX));
      send_curve(make_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
      send_curve(make_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX));
      send_curve(make_curve(-1, -1, -1, -1, -1, -1, -1, -1));
      send_curve(make_curve(16'sh5555, -16'sh5556, -16'sh5556, 16'sh5555,
                            16'sh5555, -16'sh5556, -16'sh5556, 16'sh5555));
      send_curve(make_curve(C_MAX, 0, C_MIN, 1, C_MAX, -1, C_MIN, 0));
      wait_all_samples();
   endtask

   // points, straight lines and tiny curves with rounding ties
   task automatic test_degenerate_shapes();
      send_curve(make_curve(1234, -4321, 1234, -4321, 1234, -4321, 1234, -4321));
      send_curve(make_curve(0, 0, 100, -100, 200, -200, 300, -300));
      send_curve(make_curve(0, 0, 0, 0, 0, 0, 1, -1));
      send_curve(make_curve(0, 0, 1, 1, 0, 0, 0, 0));
      send_curve(make_curve(-1, 1, 0, 0, 0, 0, 1, -1));
      send_curve(make_curve(5, -7, 5, -7, 9, 3, 9, 3));
      send_curve(make_curve(0, 0, C_MAX, C_MIN, 0, 0, 0, 0));
      send_curve(make_curve(-19, 19, 0, 0, 0, 0, 19, -19));
      wait_all_samples();
   endtask

   // no idling on either side: each new curve loads on the last sample of the previous
   task automatic test_back_to_back();
      idle_enable = 1'b0;
      repeat (30) send_curve(rand_curve());
      wait_all_samples();
      idle_enable = 1'b1;
   endtask

   // random curves with idling, pausing now and then until the pipe is empty
   task automatic test_random_curves();
      for (int i = 0; i < 380; i++) begin
         send_curve(rand_curve());
         if ($urandom_range(0, 49) == 0)
            wait_all_samples();
      end
      wait_all_samples();
   endtask

   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.p0_x  <= '0;
      req_ch.p0_y  <= '0;
      req_ch.p1_x  <= '0;
      req_ch.p1_y  <= '0;
      req_ch.p2_x  <= '0;
      req_ch.p2_y  <= '0;
      req_ch.p3_x  <= '0;
      req_ch.p3_y  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_points();
      test_degenerate_shapes();
      test_back_to_back();
      test_random_curves();

      // room for any stray beat after the last sample
      repeat (SAMPLES + 8) @(posedge clock);
      $display("%0d curves sent, %0d samples compared: corners, degenerate shapes,",
               curve_count, samples_checked);
      $display("back-to-back streaming and random curves with stalls on both sides");
      if (mismatch_count == 0 && expected_samples.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/cbs_pkg.sv
hw/rtl/cbs_if.sv
hw/rtl/cbs_issue.sv
hw/rtl/cbs_eval.sv
hw/rtl/cubic_bezier_sampler.sv
verif/tb_top.sv
